@@ sv/riff_chunk_finder_macros.svh @@
// ----------------------------------------------------------------------------
// riff_chunk_finder_macros.svh
// Assertion macros used by the chunk finder top level
// ----------------------------------------------------------------------------
`ifndef RIFF_CHUNK_FINDER_MACROS_SVH
`define RIFF_CHUNK_FINDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CHF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/chf_pkg.sv @@
// ----------------------------------------------------------------------------
// chf_pkg
// Shared types and constants of the RIFF chunk finder
// ----------------------------------------------------------------------------
package chf_pkg;

  // default target tag: "RIFF", first stream byte in bits 7:0
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] STREAM_SIZE_RST = 32'd1;

  // configuration register indexes
  localparam logic REG_TARGET_TAG  = 1'b0;
  localparam logic REG_STREAM_SIZE = 1'b1;

  // outcome codes
  localparam logic [1:0] OUT_FOUND    = 2'd0;
  localparam logic [1:0] OUT_NO_MATCH = 2'd1;
  localparam logic [1:0] OUT_OVERSIZE = 2'd2;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_search;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] chunk_length;
    logic [31:0] payload_offset;
  } out_beat_t;

  // result handed from the scanner to the output stage
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } chf_res_t;

endpackage

@@ sv/chf_scan.sv @@
// ----------------------------------------------------------------------------
// chf_scan
// Per-byte scanner state: header assembly, length check, tag compare, skip
// ----------------------------------------------------------------------------
module chf_scan
  import chf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_beat_t    beat,
  input  logic [31:0] target_tag,
  input  logic [31:0] stream_size,
  output chf_res_t    res
);

  logic [31:0] stream_position;
  logic [2:0]  header_byte_count;
  logic [31:0] tag_shift;
  logic [31:0] length_shift;
  logic [31:0] skip_remaining;
  logic        search_done;

  logic [31:0] stream_position_next;
  logic [2:0]  header_byte_count_next;
  logic [31:0] tag_shift_next;
  logic [31:0] length_shift_next;
  logic [31:0] skip_remaining_next;
  logic        search_done_next;

  // state as seen after an optional start of a new search
  logic [31:0] pos_q;
  logic [2:0]  hbc_q;
  logic [31:0] tag_q;
  logic [31:0] len_q;
  logic [31:0] skip_q;
  logic        done_q;

  logic [31:0] pos_inc;
  logic [32:0] end_sum;
  logic        give;
  logic [1:0]  code;

  assign pos_q   = beat.start_search ? '0 : stream_position;
  assign hbc_q   = beat.start_search ? '0 : header_byte_count;
  assign tag_q   = beat.start_search ? '0 : tag_shift;
  assign len_q   = beat.start_search ? '0 : length_shift;
  assign skip_q  = beat.start_search ? '0 : skip_remaining;
  assign done_q  = beat.start_search ? 1'b0 : search_done;
  assign pos_inc = pos_q + 32'd1;
  // end of header plus payload length, without wrap
  assign end_sum = {1'b0, pos_inc} + {1'b0, beat.data_byte, len_q[31:8]};

  // next-state and result decision for one byte
  always_comb begin
    stream_position_next   = pos_q;
    header_byte_count_next = hbc_q;
    tag_shift_next         = tag_q;
    length_shift_next      = len_q;
    skip_remaining_next    = skip_q;
    search_done_next       = done_q;
    give                   = 1'b0;
    code                   = OUT_NO_MATCH;
    if (done_q) begin
      // result already given, ignore byte
    end else if (skip_q != '0) begin
      skip_remaining_next  = skip_q - 32'd1;
      stream_position_next = pos_inc;
      if (skip_q == 32'd1 && pos_inc >= stream_size) begin
        give = 1'b1;
      end
    end else if (hbc_q == '0 && pos_q >= stream_size) begin
      // stream exhausted at a chunk boundary, byte not consumed
      give = 1'b1;
    end else begin
      if (!hbc_q[2]) begin
        tag_shift_next = {beat.data_byte, tag_q[31:8]};
      end else begin
        length_shift_next = {beat.data_byte, len_q[31:8]};
      end
      header_byte_count_next = hbc_q + 3'd1;
      stream_position_next   = pos_inc;
      if (hbc_q != 3'd7) begin
        if (pos_inc >= stream_size) begin
          give = 1'b1;
        end
      end else if (end_sum > {1'b0, stream_size}) begin
        give = 1'b1;
        code = OUT_OVERSIZE;
      end else if (tag_q == target_tag) begin
        give = 1'b1;
        code = OUT_FOUND;
      end else begin
        skip_remaining_next = length_shift_next;
        if (length_shift_next == '0 && pos_inc >= stream_size) begin
          give = 1'b1;
        end
      end
    end
    if (give) begin
      search_done_next = 1'b1;
    end
  end

  // result beat, length and offset only on a match
  always_comb begin
    res.valid               = accept && give;
    res.beat.outcome        = code;
    res.beat.chunk_length   = (code == OUT_FOUND) ? length_shift_next : '0;
    res.beat.payload_offset = (code == OUT_FOUND) ? pos_inc : '0;
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_position   <= '0;
      header_byte_count <= '0;
      tag_shift         <= '0;
      length_shift      <= '0;
      skip_remaining    <= '0;
      search_done       <= 1'b0;
    end else if (accept) begin
      stream_position   <= stream_position_next;
      header_byte_count <= header_byte_count_next;
      tag_shift         <= tag_shift_next;
      length_shift      <= length_shift_next;
      skip_remaining    <= skip_remaining_next;
      search_done       <= search_done_next;
    end
  end

endmodule

@@ sv/riff_chunk_finder.sv @@
// ----------------------------------------------------------------------------
// riff_chunk_finder
// Byte-serial search of a RIFF-style chunk stream for a four-character tag
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one stream byte per beat;
//   start_search set on a beat begins a new search at that byte.
//   Output channel out_valid/out_stall/out_data carries at most one result per
//   search: tag found (with length and payload offset), stream ended without
//   a match, or a chunk length that exceeds stream_size.
//   Registers target_tag (index 0) and stream_size (index 1) are written via
//   cfg_we/cfg_index/cfg_data while the block is idle.
// Timing:
//   One byte per cycle while in_stall is low; the result of a byte is
//   registered in the output register. The per-byte work is combinational in
//   the scanner between the input beat and the output register.
//   When the receiver stalls, one further result is held in a skid register;
//   in_stall rises only while that skid register is full.
// Reset:
//   Clears the search state (searching from position zero), empties the
//   output stage and restores target_tag to "RIFF" and stream_size to 1.
// ----------------------------------------------------------------------------
`include "riff_chunk_finder_macros.svh"

module riff_chunk_finder
  import chf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] target_tag;
  logic [31:0] stream_size;
  logic        in_accept;
  chf_res_t    res;
  logic        skid_valid;
  out_beat_t   skid_data;
  logic        out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_tag  <= TAG_RIFF;
      stream_size <= STREAM_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_TAG:  target_tag  <= cfg_data;
        REG_STREAM_SIZE: stream_size <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  chf_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .beat        (in_data),
    .target_tag  (target_tag),
    .stream_size (stream_size),
    .res         (res)
  );

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : res.beat;
    end
    if (!out_free && res.valid) begin
      skid_data <= res.beat;
    end
  end

  // checks
  `CHF_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "skid holds a beat while output register is empty")
  `CHF_ASSERT_NEXT(a_skid_drains, out_valid && !out_stall && skid_valid,
    out_valid && !skid_valid, "skid beat not moved into output register")
  `CHF_ASSERT_NOW(a_zero_fields, out_valid && out_data.outcome != OUT_FOUND,
    out_data.chunk_length == '0 && out_data.payload_offset == '0,
    "non-match result carries nonzero length or offset")
  `CHF_ASSERT_NOW(a_outcome_code, out_valid,
    out_data.outcome == OUT_FOUND || out_data.outcome == OUT_NO_MATCH ||
    out_data.outcome == OUT_OVERSIZE, "undefined outcome code")

endmodule

@@ tb/tb_riff_chunk_finder.sv @@
// ----------------------------------------------------------------------------
// tb_riff_chunk_finder
// Self-checking bench for the byte-serial RIFF chunk finder
// ----------------------------------------------------------------------------
// A short directed table covers reset defaults, both extremes of stream_size,
// the all-ones tag, the oversized-length and exhausted-stream outcomes and a
// found chunk. Random searches of well-formed chunk streams follow, mixed with
// truncated headers and noise, under several register settings. Each accepted
// byte runs through a scanner model in this file, and every result beat is
// compared field by field with the oldest expected result. The sender idles in
// bursts, the receiver stalls on its own pattern, and once it holds off long
// enough for the block to back up and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_riff_chunk_finder;
  import chf_pkg::*;

  localparam int ITEMS       = 1250;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int REPORT_MAX  = 100;
  localparam int PLAN_ROWS   = 31;

  typedef enum logic [1:0] {ROW_BYTE, ROW_SET_TAG, ROW_SET_SIZE} row_kind_e;

  // one row of the directed table
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] val;
    logic        start;
    logic        typed;
    logic        has_res;
    out_beat_t   res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_TARGET_TAG;
  logic [31:0] cfg_data = '0;

  // scanner model state and its copy of the registers
  logic [31:0] want_tag;
  logic [31:0] size_limit;
  logic [31:0] sc_pos;
  logic [2:0]  sc_hdr;
  logic [31:0] sc_tag;
  logic [31:0] sc_len;
  logic [31:0] sc_skip;
  bit          sc_done;

  out_beat_t   pending_results [$];
  plan_row_t   dir_plan [PLAN_ROWS];
  int          bad_count = 0;
  int          bytes_scanned = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          hold_off_req = 1'b0;

  riff_chunk_finder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic void clear_scan();
    sc_pos  = '0;
    sc_hdr  = '0;
    sc_tag  = '0;
    sc_len  = '0;
    sc_skip = '0;
    sc_done = 1'b0;
  endfunction

  function automatic void close_search(input logic [1:0] code, input logic [31:0] len,
                                       input logic [31:0] off, output out_beat_t r);
    r.outcome        = code;
    r.chunk_length   = len;
    r.payload_offset = off;
    sc_done          = 1'b1;
  endfunction

  // returns 1 when the byte produces a result
  function automatic bit scan_byte(input in_beat_t b, output out_beat_t r);
    logic [32:0] reach;
    r     = '0;
    reach = '0;
    if (b.start_search) clear_scan();
    if (sc_done) return 1'b0;
    // payload of a chunk that did not match
    if (sc_skip != 0) begin
      sc_skip = sc_skip - 32'd1;
      sc_pos  = sc_pos + 32'd1;
      if (sc_skip == 0 && sc_pos >= size_limit) begin
        close_search(OUT_NO_MATCH, '0, '0, r);
        return 1'b1;
      end
      return 1'b0;
    end
    // no room left for another header
    if (sc_hdr == 0 && sc_pos >= size_limit) begin
      close_search(OUT_NO_MATCH, '0, '0, r);
      return 1'b1;
    end
    if (sc_hdr < 4) sc_tag = {b.data_byte, sc_tag[31:8]};
    else sc_len = {b.data_byte, sc_len[31:8]};
    sc_hdr = sc_hdr + 3'd1;
    sc_pos = sc_pos + 32'd1;
    // stream ends inside a header
    if (sc_hdr != 0) begin
      if (sc_pos >= size_limit) begin
        close_search(OUT_NO_MATCH, '0, '0, r);
        return 1'b1;
      end
      return 1'b0;
    end
    // header complete: length check first, then the tag
    reach = {1'b0, sc_pos} + {1'b0, sc_len};
    if (reach > {1'b0, size_limit}) begin
      close_search(OUT_OVERSIZE, '0, '0, r);
      return 1'b1;
    end
    if (sc_tag == want_tag) begin
      close_search(OUT_FOUND, sc_len, sc_pos, r);
      return 1'b1;
    end
    sc_skip = sc_len;
    if (sc_skip == 0 && sc_pos >= size_limit) begin
      close_search(OUT_NO_MATCH, '0, '0, r);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- table rows
  function automatic plan_row_t row_byte(input logic [7:0] d, input logic s);
    plan_row_t p;
    p = '0;
    p.kind  = ROW_BYTE;
    p.val   = {24'd0, d};
    p.start = s;
    return p;
  endfunction

  function automatic plan_row_t row_want(input logic [7:0] d, input logic s, input logic has,
                                         input logic [1:0] code, input logic [31:0] len,
                                         input logic [31:0] off);
    plan_row_t p;
    p = row_byte(d, s);
    p.typed                = 1'b1;
    p.has_res              = has;
    p.res.outcome          = code;
    p.res.chunk_length     = len;
    p.res.payload_offset   = off;
    return p;
  endfunction

  function automatic plan_row_t row_cfg(input row_kind_e k, input logic [31:0] v);
    plan_row_t p;
    p = '0;
    p.kind = k;
    p.val  = v;
    return p;
  endfunction

  // ---------------------------------------------------------------- sender
  // random bursts of beats separated by idle gaps; ends at a falling edge
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // offer one byte, wait for the beat, then queue what the scanner model or the table row predicts
  task automatic feed_byte(input logic [7:0] d, input logic s, input bit typed,
                           input bit t_has, input out_beat_t t_res);
    in_beat_t  b;
    out_beat_t r;
    bit        has;
    b.data_byte    = d;
    b.start_search = s;
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = scan_byte(b, r);
    bytes_scanned++;
    if (typed) begin
      has = t_has;
      r   = t_res;
    end
    if (has) pending_results.push_back(r);
    @(negedge clk);
    pace_sender();
  endtask

  // register write once every result is out and the block has settled
  task automatic write_reg(input logic idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_TARGET_TAG) want_tag = val;
    else size_limit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one search: chunk stream with random content, truncated header or noise
  task automatic run_search();
    int          kind;
    int          nchunks;
    int          nbody;
    int          cut;
    logic [31:0] at;
    logic [31:0] tag;
    logic [31:0] len;
    logic [63:0] hdr;
    bit          lead;
    lead = ($urandom_range(0, 9) != 0);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 20)) begin
        feed_byte(8'($urandom_range(0, 255)), lead, 1'b0, 1'b0, '0);
        lead = ($urandom_range(0, 15) == 0);
      end
    end else begin
      at      = '0;
      nchunks = (kind == 1) ? 1 : $urandom_range(1, 6);
      for (int c = 0; c < nchunks; c++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: tag = want_tag;
          4, 5:       tag = want_tag ^ (32'd1 << $urandom_range(0, 31));
          default:    tag = $urandom;
        endcase
        case ($urandom_range(0, 9))
          6:       len = $urandom;
          7, 8:    len = size_limit - at - 32'd8 + 32'($urandom_range(0, 2)) - 32'd1;
          9:       len = '0;
          default: len = 32'($urandom_range(0, 5));
        endcase
        hdr = {len, tag};
        cut = (kind == 1) ? $urandom_range(1, 7) : 8;
        for (int k = 0; k < cut; k++) begin
          feed_byte(hdr[8*k +: 8], lead, 1'b0, 1'b0, '0);
          lead = 1'b0;
        end
        nbody = (len > 12) ? 12 : int'(len);
        if (kind != 1) begin
          repeat (nbody) feed_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
        end
        at = at + 32'd8 + len;
      end
      // trailing bytes, normally ignored after a result
      repeat ($urandom_range(0, 3)) feed_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    logic [31:0] v;
    bit          wrote_tag;
    bit          pressure_done;
    pressure_done = 1'b0;
    want_tag   = TAG_RIFF;
    size_limit = STREAM_SIZE_RST;
    clear_scan();

    dir_plan = '{
      // out of reset: stream size 1 ends inside the first header
      row_want(8'h52, 1'b0, 1'b1, OUT_NO_MATCH, 32'd0, 32'd0),
      row_want(8'hFF, 1'b0, 1'b0, OUT_FOUND, 32'd0, 32'd0),
      // empty stream: nothing can be consumed
      row_cfg(ROW_SET_SIZE, 32'd0),
      row_want(8'h00, 1'b1, 1'b1, OUT_NO_MATCH, 32'd0, 32'd0),
      // largest stream, all-ones tag: length check wins over the tag match
      row_cfg(ROW_SET_SIZE, 32'hFFFF_FFFF),
      row_cfg(ROW_SET_TAG, 32'hFFFF_FFFF),
      row_byte(8'hFF, 1'b1),
      row_byte(8'hFF, 1'b0),
      row_byte(8'hFF, 1'b0),
      row_byte(8'hFF, 1'b0),
      row_byte(8'hFF, 1'b0),
      row_byte(8'hFF, 1'b0),
      row_byte(8'hFF, 1'b0),
      row_want(8'hFF, 1'b0, 1'b1, OUT_OVERSIZE, 32'd0, 32'd0),
      // matching tag with a short payload
      row_byte(8'hFF, 1'b1),
      row_byte(8'hFF, 1'b0),
      row_byte(8'hFF, 1'b0),
      row_byte(8'hFF, 1'b0),
      row_byte(8'h04, 1'b0),
      row_byte(8'h00, 1'b0),
      row_byte(8'h00, 1'b0),
      row_want(8'h00, 1'b0, 1'b1, OUT_FOUND, 32'd4, 32'd8),
      // empty chunk that ends the stream exactly, tag mismatch
      row_cfg(ROW_SET_SIZE, 32'd8),
      row_byte(8'h00, 1'b1),
      row_byte(8'h00, 1'b0),
      row_byte(8'h00, 1'b0),
      row_byte(8'h00, 1'b0),
      row_byte(8'h00, 1'b0),
      row_byte(8'h00, 1'b0),
      row_byte(8'h00, 1'b0),
      row_want(8'h00, 1'b0, 1'b1, OUT_NO_MATCH, 32'd0, 32'd0)
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_plan[i]) begin
      case (dir_plan[i].kind)
        ROW_SET_TAG:  write_reg(REG_TARGET_TAG, dir_plan[i].val);
        ROW_SET_SIZE: write_reg(REG_STREAM_SIZE, dir_plan[i].val);
        default: feed_byte(dir_plan[i].val[7:0], dir_plan[i].start, dir_plan[i].typed,
                           dir_plan[i].has_res, dir_plan[i].res);
      endcase
    end

    // random phases, each under its own register setting
    bytes_scanned = 0;
    while (bytes_scanned < ITEMS) begin
      wrote_tag = 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0:       v = TAG_RIFF;
          1:       v = 32'h0000_0000;
          2:       v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
        write_reg(REG_TARGET_TAG, v);
        wrote_tag = 1'b1;
      end
      if (!wrote_tag || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       v = 32'd0;
          1:       v = 32'd1;
          2:       v = 32'hFFFF_FFFF;
          3:       v = $urandom;
          default: v = 32'($urandom_range(8, 80));
        endcase
        write_reg(REG_STREAM_SIZE, v);
      end
      repeat ($urandom_range(3, 10)) run_search();

      // back-pressure: one result per byte while the receiver holds off
      if (!pressure_done && bytes_scanned >= ITEMS / 2) begin
        write_reg(REG_STREAM_SIZE, 32'd1);
        hold_off_req = 1'b1;
        repeat (40) feed_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
        pressure_done = 1'b1;
      end
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (bad_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // stall pattern changes per segment; a requested hold-off stalls for a long run
  initial begin : receiver
    int mode;
    int seg;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      for (int k = 0; k < seg; k++) begin
        @(negedge clk);
        if (hold_off_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off_req = 1'b0;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (k % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checking
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      bad_count++;
      if (bad_count <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endtask

  // compare each result beat with the oldest expected result
  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_MAX)
          $display("%0t: unexpected result, expected none actual %h/%h/%h", $time,
                   out_data.outcome, out_data.chunk_length, out_data.payload_offset);
      end else begin
        want = pending_results.pop_front();
        check_field("outcome", {30'd0, want.outcome}, {30'd0, out_data.outcome});
        check_field("chunk_length", want.chunk_length, out_data.chunk_length);
        check_field("payload_offset", want.payload_offset, out_data.payload_offset);
      end
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
